>>> hw/rtl/cis_pkg.sv
// Shared types, constants and codes for the cone isolation sum unit.
`default_nettype none
package cis_pkg;

	localparam int SUM_BITS_DEF = 24;
	localparam int PT_W         = 16;
	localparam int ANG_W        = 12;
	localparam int DIFF_W       = ANG_W + 1;
	localparam int SQ_W         = 24;
	localparam int DSQ_W        = SQ_W + 1;
	localparam int R_W          = 10;
	localparam int CONE_SQ_W    = 2 * R_W;
	localparam int Q_W          = 16;
	localparam int DC_W         = 11;
	localparam int CFG_IDX_W    = 2;
	localparam int CFG_DATA_W   = 16;
	localparam int KIND_W       = 2;
	localparam int PDG_W        = 9;
	localparam int VLINK_W      = 2;
	localparam int FRAC_SHIFT   = 9;

	localparam logic [PT_W-1:0] PT_LOW_LIMIT = 16'd320;
	localparam logic [PT_W-1:0] PT_THRESH    = 16'd32;
	localparam logic signed [ANG_W-1:0] ENDCAP_ETA = 12'sd757;
	localparam logic signed [DIFF_W-1:0] PHI_PI  = 13'sd1608;
	localparam logic signed [DIFF_W-1:0] PHI_2PI = 13'sd3217;

	localparam logic [DC_W-1:0] DC_NONE       = 11'd0;
	localparam logic [DC_W-1:0] DC_ELE_CH     = 11'd59;
	localparam logic [DC_W-1:0] DC_ELE_PH     = 11'd1678;
	localparam logic [DC_W-1:0] DC_MU_CH      = 11'd1;
	localparam logic [DC_W-1:0] DC_MU_NEUTRAL = 11'd27;

	localparam logic [PDG_W-1:0] PDG_MIN     = 9'd7;
	localparam logic [PDG_W-1:0] PDG_PHOTON  = 9'd22;
	localparam logic [PDG_W-1:0] PDG_K0_LONG = 9'd130;
	localparam logic [PDG_W-1:0] PDG_PION    = 9'd211;

	localparam logic [KIND_W-1:0] KIND_ELECTRON = 2'd1;
	localparam logic [KIND_W-1:0] KIND_MUON     = 2'd2;

	localparam logic [VLINK_W-1:0] VLINK_LOOSE = 2'd1;

	localparam logic [CFG_IDX_W-1:0] CFG_CONE_MIN     = 2'd0;
	localparam logic [CFG_IDX_W-1:0] CFG_CONE_MAX     = 2'd1;
	localparam logic [CFG_IDX_W-1:0] CFG_RADIUS_SCALE = 2'd2;
	localparam logic [CFG_IDX_W-1:0] CFG_CHARGED_ONLY = 2'd3;

	localparam logic [1:0] BIN_PH = 2'd0;
	localparam logic [1:0] BIN_NH = 2'd1;
	localparam logic [1:0] BIN_CH = 2'd2;
	localparam logic [1:0] BIN_PU = 2'd3;

	localparam logic [R_W-1:0]  CONE_MIN_RST     = 10'd26;
	localparam logic [R_W-1:0]  CONE_MAX_RST     = 10'd102;
	localparam logic [PT_W-1:0] RADIUS_SCALE_RST = 16'd640;

	typedef enum logic [3:0] {
		ST_IDLE,
		ST_SQ,
		ST_ACC,
		ST_REF,
		ST_DIV_REF,
		ST_CLAMP,
		ST_CONE,
		ST_RES_S2,
		ST_RES_SUM,
		ST_RES_START,
		ST_DIV_RES,
		ST_OUT
	} cis_state_t;

	typedef struct packed {
		logic                    func;
		logic [PT_W-1:0]         pt;
		logic signed [ANG_W-1:0] eta;
		logic signed [ANG_W-1:0] phi;
		logic [KIND_W-1:0]       kind;
		logic [PDG_W-1:0]        abs_pdg;
		logic                    is_charged;
		logic [VLINK_W-1:0]      vertex_link;
		logic                    last;
	} cis_item_t;

	typedef struct packed {
		logic in_take;
		logic sq;
		logic acc;
		logic ref_load;
		logic div_start_ref;
		logic div_start_res;
		logic clamp;
		logic cone;
		logic res_s2;
		logic res_sum;
		logic out_load;
	} cis_cmd_t;

	typedef struct packed {
		logic last_s1;
		logic last_s2;
		logic div_done;
		logic out_free;
	} cis_sts_t;

endpackage
`default_nettype wire

>>> hw/rtl/cis_if.sv
// Valid/ready channel interfaces for input items and result items.
`default_nettype none
interface cis_item_if;
	import cis_pkg::*;
	logic                    valid;
	logic                    ready;
	logic                    func;
	logic [PT_W-1:0]         pt;
	logic signed [ANG_W-1:0] eta;
	logic signed [ANG_W-1:0] phi;
	logic [KIND_W-1:0]       kind;
	logic [PDG_W-1:0]        abs_pdg;
	logic                    is_charged;
	logic [VLINK_W-1:0]      vertex_link;
	logic                    last;

	modport source (
		output valid, func, pt, eta, phi, kind, abs_pdg, is_charged, vertex_link, last,
		input  ready
	);
	modport sink (
		input  valid, func, pt, eta, phi, kind, abs_pdg, is_charged, vertex_link, last,
		output ready
	);
endinterface

interface cis_result_if;
	import cis_pkg::*;
	logic           valid;
	logic           ready;
	logic [Q_W-1:0] iso_ratio;
	logic           low_pt;

	modport source (output valid, iso_ratio, low_pt, input ready);
	modport sink (input valid, iso_ratio, low_pt, output ready);
endinterface
`default_nettype wire

>>> hw/rtl/cis_div.sv
// Restoring divider, one quotient bit per cycle, 16-bit saturating quotient.
`default_nettype none
module cis_div
	import cis_pkg::*;
#(
	parameter int DIV_W = SUM_BITS_DEF + Q_W
) (
	input  wire logic             clk,
	input  wire logic             arst_n,
	input  wire logic             start,
	input  wire logic [DIV_W-1:0] dividend,
	input  wire logic [PT_W-1:0]  divisor,
	output logic                  done,
	output logic [Q_W-1:0]        quo
);

	localparam int HI_W  = DIV_W - Q_W;
	localparam int CNT_W = $clog2(Q_W + 1);

	logic [CNT_W-1:0] cnt_q;
	logic [PT_W-1:0]  rem_q;
	logic [Q_W-1:0]   low_q;
	logic [Q_W-1:0]   quo_q;
	logic [PT_W-1:0]  dvs_q;
	logic             sat_q;

	logic [HI_W-1:0]  hi;
	logic [PT_W:0]    trial;
	logic [PT_W:0]    diff;
	logic             ge;

	assign hi    = dividend[DIV_W-1:Q_W];
	assign trial = {rem_q, low_q[Q_W-1]};
	assign diff  = trial - {1'b0, dvs_q};
	assign ge    = trial >= {1'b0, dvs_q};
	assign done  = cnt_q == '0;
	assign quo   = sat_q ? '1 : quo_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cnt_q <= '0;
		end else if (start) begin
			cnt_q <= CNT_W'(Q_W);
		end else if (!done) begin
			cnt_q <= cnt_q - CNT_W'(1);
		end
	end

	always_ff @(posedge clk) begin
		if (start) begin
			sat_q <= hi >= HI_W'(divisor);
			rem_q <= hi[PT_W-1:0];
			low_q <= dividend[Q_W-1:0];
			dvs_q <= divisor;
			quo_q <= '0;
		end else if (!done) begin
			rem_q <= ge ? diff[PT_W-1:0] : trial[PT_W-1:0];
			low_q <= {low_q[Q_W-2:0], 1'b0};
			quo_q <= {quo_q[Q_W-2:0], ge};
		end
	end

endmodule
`default_nettype wire

>>> hw/rtl/cis_datapath.sv
// Datapath: configuration, reference registers, distance stages, bins, divider, output register.
`default_nettype none
module cis_datapath
	import cis_pkg::*;
#(
	parameter int SUM_BITS = SUM_BITS_DEF
) (
	input  wire logic                  clk,
	input  wire logic                  arst_n,
	input  wire logic                  cfg_we,
	input  wire logic [CFG_IDX_W-1:0]  cfg_index,
	input  wire logic [CFG_DATA_W-1:0] cfg_data,
	input  wire cis_item_t             item,
	input  wire cis_cmd_t              cmd,
	output cis_sts_t                   sts,
	input  wire logic                  out_ready,
	output logic                       out_valid,
	output logic [Q_W-1:0]             iso_ratio,
	output logic                       low_pt
);

	localparam int DIV_W = SUM_BITS + Q_W;
	localparam int S2_W  = SUM_BITS + 3;

	// configuration
	logic [R_W-1:0]  cone_min_q;
	logic [R_W-1:0]  cone_max_q;
	logic [PT_W-1:0] radius_scale_q;
	logic            charged_only_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cone_min_q     <= CONE_MIN_RST;
			cone_max_q     <= CONE_MAX_RST;
			radius_scale_q <= RADIUS_SCALE_RST;
			charged_only_q <= 1'b0;
		end else if (cfg_we) begin
			unique case (cfg_index)
				CFG_CONE_MIN:     cone_min_q     <= cfg_data[R_W-1:0];
				CFG_CONE_MAX:     cone_max_q     <= cfg_data[R_W-1:0];
				CFG_RADIUS_SCALE: radius_scale_q <= cfg_data;
				CFG_CHARGED_ONLY: charged_only_q <= cfg_data[0];
				default: ;
			endcase
		end
	end

	// reference state
	logic [PT_W-1:0]         ref_pt_q;
	logic signed [ANG_W-1:0] ref_eta_q;
	logic signed [ANG_W-1:0] ref_phi_q;
	logic [KIND_W-1:0]       ref_kind_q;
	logic [CONE_SQ_W-1:0]    cone_sq_q;
	logic [R_W-1:0]          r_q;

	// stage 1: captured item and angular differences
	cis_item_t                item_s1;
	logic signed [DIFF_W-1:0] deta_s1;
	logic signed [DIFF_W-1:0] dphi_s1;
	logic signed [DIFF_W-1:0] deta;
	logic signed [DIFF_W-1:0] dphi_raw;
	logic signed [DIFF_W-1:0] dphi;

	always_comb begin
		deta     = $signed({item.eta[ANG_W-1], item.eta}) - $signed({ref_eta_q[ANG_W-1], ref_eta_q});
		dphi_raw = $signed({item.phi[ANG_W-1], item.phi}) - $signed({ref_phi_q[ANG_W-1], ref_phi_q});
		if (dphi_raw > PHI_PI) begin
			dphi = dphi_raw - PHI_2PI;
		end else if (dphi_raw < -PHI_PI) begin
			dphi = dphi_raw + PHI_2PI;
		end else begin
			dphi = dphi_raw;
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.in_take) begin
			item_s1 <= item;
			deta_s1 <= deta;
			dphi_s1 <= dphi;
		end
	end

	// stage 2: squares
	logic signed [2*DIFF_W-1:0] deta_p;
	logic signed [2*DIFF_W-1:0] dphi_p;
	logic [SQ_W-1:0]            deta_sq_s2;
	logic [SQ_W-1:0]            dphi_sq_s2;
	logic [PT_W-1:0]            pt_s2;
	logic [PDG_W-1:0]           pdg_s2;
	logic                       chg_s2;
	logic [VLINK_W-1:0]         vlink_s2;
	logic                       last_s2;

	assign deta_p = (2*DIFF_W)'(deta_s1) * (2*DIFF_W)'(deta_s1);
	assign dphi_p = (2*DIFF_W)'(dphi_s1) * (2*DIFF_W)'(dphi_s1);

	always_ff @(posedge clk) begin
		if (cmd.sq) begin
			deta_sq_s2 <= deta_p[SQ_W-1:0];
			dphi_sq_s2 <= dphi_p[SQ_W-1:0];
			pt_s2      <= item_s1.pt;
			pdg_s2     <= item_s1.abs_pdg;
			chg_s2     <= item_s1.is_charged;
			vlink_s2   <= item_s1.vertex_link;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			last_s2 <= 1'b0;
		end else if (cmd.sq) begin
			last_s2 <= item_s1.last;
		end
	end

	// accumulate: cone test, dead cones, bin select
	logic [DSQ_W-1:0]    dsq;
	logic [DC_W-1:0]     dc_ch, dc_pu, dc_ph, dc_nh;
	logic [PT_W-1:0]     thr;
	logic                endcap;
	logic                bin_en;
	logic [1:0]          bin_idx;
	logic [SUM_BITS-1:0] bin_q [4];
	logic [SUM_BITS:0]   bin_sum;
	logic [SUM_BITS-1:0] bin_next;

	always_comb begin
		dsq    = {1'b0, deta_sq_s2} + {1'b0, dphi_sq_s2};
		endcap = (ref_eta_q > ENDCAP_ETA) || (ref_eta_q < -ENDCAP_ETA);
		thr    = (ref_kind_q == KIND_ELECTRON) ? '0 : PT_THRESH;
		dc_ch  = DC_NONE;
		dc_pu  = DC_NONE;
		dc_ph  = DC_NONE;
		dc_nh  = DC_NONE;
		if (ref_kind_q == KIND_ELECTRON) begin
			if (endcap) begin
				dc_ch = DC_ELE_CH;
				dc_pu = DC_ELE_CH;
				dc_ph = DC_ELE_PH;
			end
		end else if (ref_kind_q == KIND_MUON) begin
			dc_ch = DC_MU_CH;
			dc_pu = DC_MU_NEUTRAL;
			dc_ph = DC_MU_NEUTRAL;
			dc_nh = DC_MU_NEUTRAL;
		end
		bin_en  = 1'b0;
		bin_idx = BIN_PH;
		if (pdg_s2 >= PDG_MIN && dsq <= DSQ_W'(cone_sq_q)) begin
			if (!chg_s2) begin
				if (pt_s2 > thr) begin
					if (pdg_s2 == PDG_PHOTON) begin
						bin_en  = dsq >= DSQ_W'(dc_ph);
						bin_idx = BIN_PH;
					end else if (pdg_s2 == PDG_K0_LONG) begin
						bin_en  = dsq >= DSQ_W'(dc_nh);
						bin_idx = BIN_NH;
					end
				end
			end else if (vlink_s2 > VLINK_LOOSE) begin
				bin_en  = (pdg_s2 == PDG_PION) && (dsq >= DSQ_W'(dc_ch));
				bin_idx = BIN_CH;
			end else begin
				bin_en  = (pt_s2 > thr) && (dsq >= DSQ_W'(dc_pu));
				bin_idx = BIN_PU;
			end
		end
		bin_sum  = {1'b0, bin_q[bin_idx]} + (SUM_BITS + 1)'(pt_s2);
		bin_next = bin_sum[SUM_BITS] ? '1 : bin_sum[SUM_BITS-1:0];
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			for (int i = 0; i < 4; i++) begin
				bin_q[i] <= '0;
			end
		end else if (cmd.ref_load) begin
			for (int i = 0; i < 4; i++) begin
				bin_q[i] <= '0;
			end
		end else if (cmd.acc && bin_en) begin
			bin_q[bin_idx] <= bin_next;
		end
	end

	// reference load and cone radius
	logic [Q_W-1:0]   div_quo;
	logic             div_done;
	logic [DIV_W-1:0] div_dividend;
	logic [PT_W-1:0]  div_divisor;
	logic [R_W-1:0]   r_clip;
	logic [R_W-1:0]   r_new;

	always_comb begin
		r_clip = (div_quo < Q_W'(cone_max_q)) ? div_quo[R_W-1:0] : cone_max_q;
		r_new  = (r_clip < cone_min_q) ? cone_min_q : r_clip;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			ref_pt_q   <= '0;
			ref_eta_q  <= '0;
			ref_phi_q  <= '0;
			ref_kind_q <= '0;
			cone_sq_q  <= '0;
		end else begin
			if (cmd.ref_load) begin
				ref_pt_q   <= item_s1.pt;
				ref_eta_q  <= item_s1.eta;
				ref_phi_q  <= item_s1.phi;
				ref_kind_q <= item_s1.kind;
			end
			if (cmd.cone) begin
				cone_sq_q <= CONE_SQ_W'(r_q) * CONE_SQ_W'(r_q);
			end
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.clamp) begin
			r_q <= r_new;
		end
	end

	// result sum
	logic [SUM_BITS:0]          phnh;
	logic signed [S2_W-1:0]     s2_q;
	logic [SUM_BITS:0]          ch2_q;
	logic [S2_W-1:0]            sum_q;
	logic                       s2_nonpos;

	assign phnh      = {1'b0, bin_q[BIN_PH]} + {1'b0, bin_q[BIN_NH]};
	assign s2_nonpos = s2_q[S2_W-1] || (s2_q == '0);

	always_ff @(posedge clk) begin
		if (cmd.res_s2) begin
			s2_q  <= $signed({1'b0, phnh, 1'b0}) - $signed({3'b000, bin_q[BIN_PU]});
			ch2_q <= {bin_q[BIN_CH], 1'b0};
		end
		if (cmd.res_sum) begin
			sum_q <= (charged_only_q || s2_nonpos) ? S2_W'(ch2_q)
			                                       : $unsigned(s2_q) + S2_W'(ch2_q);
		end
	end

	// shared divider
	assign div_dividend = cmd.div_start_ref ? DIV_W'({radius_scale_q, FRAC_SHIFT'(0)})
	                                        : DIV_W'({sum_q, FRAC_SHIFT'(0)});
	assign div_divisor  = cmd.div_start_ref ? item_s1.pt : ref_pt_q;

	cis_div #(
		.DIV_W (DIV_W)
	) u_div (
		.clk      (clk),
		.arst_n   (arst_n),
		.start    (cmd.div_start_ref || cmd.div_start_res),
		.dividend (div_dividend),
		.divisor  (div_divisor),
		.done     (div_done),
		.quo      (div_quo)
	);

	// output register
	logic           out_valid_q;
	logic [Q_W-1:0] iso_ratio_q;
	logic           low_pt_q;
	logic           is_low;

	assign is_low = ref_pt_q < PT_LOW_LIMIT;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (cmd.out_load) begin
			out_valid_q <= 1'b1;
		end else if (out_ready) begin
			out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.out_load) begin
			iso_ratio_q <= is_low ? '1 : div_quo;
			low_pt_q    <= is_low;
		end
	end

	assign out_valid = out_valid_q;
	assign iso_ratio = iso_ratio_q;
	assign low_pt    = low_pt_q;

	assign sts.last_s1  = item_s1.last;
	assign sts.last_s2  = last_s2;
	assign sts.div_done = div_done;
	assign sts.out_free = !out_valid_q || out_ready;

endmodule
`default_nettype wire

>>> hw/rtl/cis_ctrl.sv
// Controller state machine: sequences accumulate, reference load and result steps.
`default_nettype none
module cis_ctrl
	import cis_pkg::*;
(
	input  wire logic     clk,
	input  wire logic     arst_n,
	input  wire logic     in_valid,
	input  wire logic     in_func,
	input  wire cis_sts_t sts,
	output logic          in_ready,
	output cis_cmd_t      cmd
);

	cis_state_t state_q;
	cis_state_t state_d;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_IDLE;
		end else begin
			state_q <= state_d;
		end
	end

	always_comb begin
		state_d = state_q;
		unique case (state_q)
			ST_IDLE: begin
				if (in_valid) begin
					state_d = in_func ? ST_SQ : ST_REF;
				end
			end
			ST_SQ: state_d = ST_ACC;
			ST_ACC: begin
				if (sts.last_s2) begin
					state_d = ST_RES_S2;
				end else if (in_valid) begin
					state_d = in_func ? ST_SQ : ST_REF;
				end else begin
					state_d = ST_IDLE;
				end
			end
			ST_REF: state_d = ST_DIV_REF;
			ST_DIV_REF: begin
				if (sts.div_done) begin
					state_d = ST_CLAMP;
				end
			end
			ST_CLAMP: state_d = ST_CONE;
			ST_CONE: state_d = sts.last_s1 ? ST_RES_S2 : ST_IDLE;
			ST_RES_S2: state_d = ST_RES_SUM;
			ST_RES_SUM: state_d = ST_RES_START;
			ST_RES_START: state_d = ST_DIV_RES;
			ST_DIV_RES: begin
				if (sts.div_done) begin
					state_d = ST_OUT;
				end
			end
			ST_OUT: begin
				if (sts.out_free) begin
					state_d = ST_IDLE;
				end
			end
			default: state_d = ST_IDLE;
		endcase
	end

	always_comb begin
		cmd      = '0;
		in_ready = 1'b0;
		unique case (state_q)
			ST_IDLE:      in_ready = 1'b1;
			ST_SQ:        cmd.sq = 1'b1;
			ST_ACC: begin
				cmd.acc  = 1'b1;
				in_ready = !sts.last_s2;
			end
			ST_REF: begin
				cmd.ref_load      = 1'b1;
				cmd.div_start_ref = 1'b1;
			end
			ST_DIV_REF:   ;
			ST_CLAMP:     cmd.clamp = sts.div_done;
			ST_CONE:      cmd.cone = 1'b1;
			ST_RES_S2:    cmd.res_s2 = 1'b1;
			ST_RES_SUM:   cmd.res_sum = 1'b1;
			ST_RES_START: cmd.div_start_res = 1'b1;
			ST_DIV_RES:   ;
			ST_OUT:       cmd.out_load = sts.out_free;
			default:      ;
		endcase
		cmd.in_take = in_valid && in_ready;
	end

	a_out_load_free: assert property (@(posedge clk) disable iff (!arst_n)
		cmd.out_load |-> sts.out_free)
		else $error("result loaded while output register busy");

	a_div_start_idle: assert property (@(posedge clk) disable iff (!arst_n)
		(cmd.div_start_ref || cmd.div_start_res) |-> sts.div_done)
		else $error("divider started while busy");

	a_take_spacing: assert property (@(posedge clk) disable iff (!arst_n)
		cmd.in_take |=> !cmd.in_take)
		else $error("items taken in consecutive cycles");

	a_acc_after_sq: assert property (@(posedge clk) disable iff (!arst_n)
		cmd.sq |=> cmd.acc)
		else $error("squares not followed by accumulate");

endmodule
`default_nettype wire

>>> hw/rtl/cone_isolation_sum_unit.sv
// Top level of the cone isolation sum unit: controller, datapath and channel wiring.
//
//  channel  role    handshake     payload
//  in_item  sink    valid/ready   func pt eta phi kind abs_pdg is_charged vertex_link last
//  res      source  valid/ready   iso_ratio low_pt
//  cfg      write   cfg_we        cfg_index cfg_data
//
// A candidate item is squared and then accumulated; unless it is last, the next item is taken while it accumulates.
// A reference item waits on the 16-step shared divider for the radius, which is then clamped and squared.
// A last item then adds the result sum and the ratio division before the next take.
// Reset is asynchronous and clears the configuration, the reference state, the bins, the state and the output valid.
// The result register holds a result while res.ready is low; res.ready stalls the unit only once it is full.
`default_nettype none
module cone_isolation_sum_unit
	import cis_pkg::*;
#(
	parameter int SUM_BITS = SUM_BITS_DEF
) (
	input  wire logic                  clk,
	input  wire logic                  arst_n,
	input  wire logic                  cfg_we,
	input  wire logic [CFG_IDX_W-1:0]  cfg_index,
	input  wire logic [CFG_DATA_W-1:0] cfg_data,
	cis_item_if.sink                   in_item,
	cis_result_if.source               res
);

	cis_item_t item;
	cis_cmd_t  cmd;
	cis_sts_t  sts;

	assign item.func        = in_item.func;
	assign item.pt          = in_item.pt;
	assign item.eta         = in_item.eta;
	assign item.phi         = in_item.phi;
	assign item.kind        = in_item.kind;
	assign item.abs_pdg     = in_item.abs_pdg;
	assign item.is_charged  = in_item.is_charged;
	assign item.vertex_link = in_item.vertex_link;
	assign item.last        = in_item.last;

	cis_ctrl u_ctrl (
		.clk      (clk),
		.arst_n   (arst_n),
		.in_valid (in_item.valid),
		.in_func  (in_item.func),
		.sts      (sts),
		.in_ready (in_item.ready),
		.cmd      (cmd)
	);

	cis_datapath #(
		.SUM_BITS (SUM_BITS)
	) u_dp (
		.clk       (clk),
		.arst_n    (arst_n),
		.cfg_we    (cfg_we),
		.cfg_index (cfg_index),
		.cfg_data  (cfg_data),
		.item      (item),
		.cmd       (cmd),
		.sts       (sts),
		.out_ready (res.ready),
		.out_valid (res.valid),
		.iso_ratio (res.iso_ratio),
		.low_pt    (res.low_pt)
	);

endmodule
`default_nettype wire
